[src/hexe_pkg.sv]
// Shared types, character codes and helper functions for the hex escape encoder.
// No dependencies; every other file of the block imports this package.
package hexe_pkg;

  localparam int unsigned WinDepth = 4;
  localparam int unsigned IdxW     = $clog2(WinDepth);

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] PrintLo     = 8'h20;
  localparam logic [7:0] PrintHi     = 8'h7e;
  localparam logic [7:0] NibHiMask   = 8'hf0;
  localparam logic [7:0] NibLoMask   = 8'h0f;

  // Position inside a four-byte escape
  localparam logic [1:0] SubBackslash = 2'd0;
  localparam logic [1:0] SubX         = 2'd1;
  localparam logic [1:0] SubHigh      = 2'd2;
  localparam logic [1:0] SubLow       = 2'd3;

  localparam logic [15:0][7:0] HexDigits = {
    8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // One decided group of bytes handed from the window to the serialiser
  typedef struct packed {
    logic [WinDepth-1:0][7:0] bytes;
    logic [WinDepth-1:0]      esc;
    logic [IdxW-1:0]          top_idx;
    logic                     last;
  } hexe_job_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
        ((c >= 8'h41) && (c <= 8'h46));
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    r = HexDigits[nib];
    return r;
  endfunction

endpackage

[src/hexe_window.sv]
// Lookahead window: holds up to three earlier bytes and decides which bytes leave
// and whether each is escaped. Depends on hexe_pkg.
module hexe_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              escape_all,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              job_ready,
  output logic              job_load,
  output hexe_pkg::hexe_job_t job
);
  import hexe_pkg::*;

  logic [2:0][7:0] la_r, la_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [WinDepth-1:0][7:0] win;
  logic            accept;
  logic            full;
  logic            seq;
  logic [WinDepth-1:0] base_esc;

  assign in_ready = job_ready;
  assign accept   = in_valid && job_ready;
  assign full     = (cnt_r == 2'd3);

  // Build the window: held bytes, then the new byte
  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      if (3'(k) < {1'b0, cnt_r}) begin
        win[k] = (k < 3) ? la_r[k[1:0]] : 8'h00;
      end else if (3'(k) == {1'b0, cnt_r}) begin
        win[k] = in_byte;
      end else begin
        win[k] = 8'h00;
      end
    end
  end

  // Classify bytes
  assign seq = full && (win[0] == ChBackslash) && (win[1] == ChX) &&
               is_hex(win[2]) && is_hex(win[3]);

  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      base_esc[k] = escape_all || (win[k] < PrintLo) || (win[k] > PrintHi);
    end
  end

  // Form the job: oldest byte on a full window, every byte on the last item
  always_comb begin
    job.bytes   = win;
    job.esc     = base_esc;
    job.esc[0]  = base_esc[0] || seq;
    job.last    = in_last;
    job.top_idx = in_last ? cnt_r : '0;
    job_load    = accept && (in_last || full);
  end

  // Advance the lookahead
  always_comb begin
    la_nxt  = la_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last) begin
        la_nxt  = '0;
        cnt_nxt = '0;
      end else if (full) begin
        la_nxt  = {win[3], win[2], win[1]};
        cnt_nxt = 2'd3;
      end else begin
        la_nxt[cnt_r] = in_byte;
        cnt_nxt       = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r  <= '0;
      cnt_r <= '0;
    end else begin
      la_r  <= la_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/hexe_serializer.sv]
// Output serialiser: holds one job and sends its bytes, raw or as \xHH, one per
// cycle unless stalled, through a registered output. Depends on hexe_pkg.
module hexe_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_load,
  input  hexe_pkg::hexe_job_t job,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import hexe_pkg::*;

  hexe_job_t        job_r;
  logic             job_valid_r, job_valid_nxt;
  logic [IdxW-1:0]  pos_r, pos_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       cur;
  logic             cur_esc;
  logic             move;
  logic             byte_done;
  logic             job_done;

  assign cur       = job_r.bytes[pos_r];
  assign cur_esc   = job_r.esc[pos_r];
  assign move      = job_valid_r && (!out_valid_r || out_ready);
  assign byte_done = !cur_esc || (sub_r == SubLow);
  assign job_done  = byte_done && (pos_r == job_r.top_idx);
  assign job_ready = !job_valid_r || (move && job_done);

  // Walk the job
  always_comb begin
    job_valid_nxt = job_valid_r;
    pos_nxt       = pos_r;
    sub_nxt       = sub_r;
    if (job_load) begin
      job_valid_nxt = 1'b1;
      pos_nxt       = '0;
      sub_nxt       = SubBackslash;
    end else if (move) begin
      if (job_done) begin
        job_valid_nxt = 1'b0;
      end else if (byte_done) begin
        pos_nxt = pos_r + IdxW'(1);
        sub_nxt = SubBackslash;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  // Pick the next output byte and hold it while stalled
  always_comb begin
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = job_r.last && job_done;
      case (sub_r)
        SubBackslash: out_byte_nxt = cur_esc ? ChBackslash : cur;
        SubX:         out_byte_nxt = ChX;
        SubHigh:      out_byte_nxt = hex_char(4'((cur & NibHiMask) >> 4));
        default:      out_byte_nxt = hex_char(4'(cur & NibLoMask));
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      sub_r       <= SubBackslash;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      sub_r       <= sub_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[src/hex_escape_encoder_unit.sv]
// Top level of the backslash-x hex escape encoder: config register, lookahead
// window and output serialiser. Depends on hexe_pkg, hexe_window, hexe_serializer.
//
//   channel   direction  handshake            payload
//   in_       slave      in_tvalid/in_tready  tdata = byte, tlast = last of string
//   out_      master     out_tvalid/out_tready tdata = byte, tlast = last of string
//   cfg_      write      cfg_wr_en            cfg_wr_data = escape_all
//
// A byte passed through raw gives one output byte, an escaped byte four; a last
// item flushes up to four bytes. The serialiser sends a single output byte per
// cycle unless the output stalls; the first three bytes of a string only fill
// the window. Reset clears the window, the escape_all register and all valid
// flags. A stall on the output holds the byte in the output register while the
// serialiser keeps the pending job; input is taken again as soon as the job's
// last byte moves into the output register.
module hex_escape_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import hexe_pkg::*;

  logic      escape_all_r, escape_all_nxt;
  logic      job_ready;
  logic      job_load;
  hexe_job_t job;

  // Hold the escape_all register
  assign escape_all_nxt = cfg_wr_en ? cfg_wr_data : escape_all_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_all_r <= 1'b0;
    end else begin
      escape_all_r <= escape_all_nxt;
    end
  end

  hexe_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .escape_all (escape_all_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .job_ready  (job_ready),
    .job_load   (job_load),
    .job        (job)
  );

  hexe_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (job_load),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
